### rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// shared types, codes and constants of the command stream deframer
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int MAX_RES    = 5;
  localparam int RES_IDX_W  = $clog2(MAX_RES);

  localparam logic [16:0] STREAM_HDR_BYTES = 17'd3;
  localparam logic [15:0] BULK_HDR_BYTES   = 16'd11;
  localparam logic [16:0] BULK_LAST_INDEX  = 17'd10;
  localparam logic [8:0]  FN_HDR_BYTES     = 9'd4;

  localparam logic [7:0]  STREAM_OP_RST  = 8'd50;
  localparam logic [7:0]  MAX_BIN_RST    = 8'd49;
  localparam logic [7:0]  BULK_OP_RST    = 8'd128;
  localparam logic [7:0]  FN_OP_RST      = 8'd131;
  localparam logic [7:0]  NAME_LIM_RST   = 8'd64;
  localparam logic [15:0] MAX_LEN_RST    = 16'd1024;

  typedef enum logic [2:0] {
    CFG_STREAM_OP = 3'd0,
    CFG_MAX_BIN   = 3'd1,
    CFG_BULK_OP   = 3'd2,
    CFG_FN_OP     = 3'd3,
    CFG_NAME_LIM  = 3'd4,
    CFG_MAX_LEN   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_BIN      = 3'd1,
    PH_STR_HDR  = 3'd2,
    PH_STR_BODY = 3'd3,
    PH_BULK_HDR = 3'd4,
    PH_BULK_PAY = 3'd5,
    PH_FN_HDR   = 3'd6,
    PH_FN_BODY  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_BINARY   = 3'd0,
    KIND_STREAM   = 3'd1,
    KIND_BULK_HDR = 3'd2,
    KIND_BULK_PAY = 3'd3,
    KIND_FILENAME = 3'd4,
    KIND_DROP     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    RSN_NONE      = 2'd0,
    RSN_UNKNOWN   = 2'd1,
    RSN_OVERSIZED = 2'd2,
    RSN_BAD_NAME  = 2'd3
  } reason_t;

  // one queued command: expands into cnt results
  typedef struct packed {
    logic [RES_IDX_W-1:0]           cnt;
    logic [MAX_RES-1:0][7:0]        dat;
    kind_t                          kind;
    logic [7:0]                     op;
    logic [15:0]                    flen;
    logic [31:0]                    plen;
    reason_t                        reason;
    logic                           first_start;
    logic                           last_end;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/csd_in_if.sv
// ----------------------------------------------------------------------------
// csd_in_if
// received byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface csd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_reset;

  modport source (output valid, output rx_byte, output link_reset, input ready);
  modport sink   (input valid, input rx_byte, input link_reset, output ready);
endinterface

`default_nettype wire

### rtl/csd_out_if.sv
// ----------------------------------------------------------------------------
// csd_out_if
// result channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface csd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic        frame_start;
  logic        frame_end;
  logic [7:0]  frame_op;
  logic [15:0] frame_len;
  logic [31:0] bulk_len;
  logic [1:0]  drop_reason;
  logic        run_end;

  modport source (output valid, output kind, output data, output frame_start,
                  output frame_end, output frame_op, output frame_len,
                  output bulk_len, output drop_reason, output run_end,
                  input ready);
  modport sink   (input valid, input kind, input data, input frame_start,
                  input frame_end, input frame_op, input frame_len,
                  input bulk_len, input drop_reason, input run_end,
                  output ready);
endinterface

`default_nettype wire

### rtl/csd_front.sv
// ----------------------------------------------------------------------------
// csd_front
// configuration registers and frame parser; turns each item into at most
// one command for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module csd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  csd_in_if.sink             in_ch,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  input  wire logic          q_full,
  output logic               push,
  output csd_pkg::cmd_t      cmd
);

  logic [7:0]  stream_op_r, max_bin_r, bulk_op_r, fn_op_r, name_lim_r;
  logic [15:0] max_len_r;

  csd_pkg::phase_t phase_r, phase_nxt;
  logic [16:0] idx_r, idx_nxt;
  logic [31:0] need_r, need_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [31:0] bcnt_r, bcnt_nxt;
  logic [7:0]  held0_r, held0_nxt, held1_r, held1_nxt, held2_r, held2_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [16:0] idx_inc;
  logic        idx_end;
  logic [16:0] str_total;
  logic        str_big;
  logic [1:0]  bulk_sh;
  logic [31:0] bulk_need;
  logic        bulk_end;
  logic [31:0] pay_inc;
  logic        pay_end;
  logic [8:0]  fn_total;
  logic        fn_bad;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.rx_byte;

  assign idx_inc   = idx_r + 17'd1;
  assign idx_end   = {15'd0, idx_inc} >= need_r;
  assign str_total = csd_pkg::STREAM_HDR_BYTES + {1'b0, b, held1_r};
  assign str_big   = str_total > {1'b0, max_len_r};
  assign bulk_sh   = 2'(idx_r[1:0] + 2'd1);
  assign bulk_need = (idx_r >= 17'd3 && idx_r <= 17'd6)
                     ? (need_r | ({24'd0, b} << {bulk_sh, 3'b000})) : need_r;
  assign bulk_end  = idx_r >= csd_pkg::BULK_LAST_INDEX;
  assign pay_inc   = bcnt_r + 32'd1;
  assign pay_end   = pay_inc >= need_r;
  assign fn_total  = csd_pkg::FN_HDR_BYTES + {1'b0, b};
  assign fn_bad    = (b == 8'd0) || (b >= name_lim_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_op_r <= csd_pkg::STREAM_OP_RST;
      max_bin_r   <= csd_pkg::MAX_BIN_RST;
      bulk_op_r   <= csd_pkg::BULK_OP_RST;
      fn_op_r     <= csd_pkg::FN_OP_RST;
      name_lim_r  <= csd_pkg::NAME_LIM_RST;
      max_len_r   <= csd_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        csd_pkg::CFG_STREAM_OP: stream_op_r <= cfg_wdata[7:0];
        csd_pkg::CFG_MAX_BIN:   max_bin_r   <= cfg_wdata[7:0];
        csd_pkg::CFG_BULK_OP:   bulk_op_r   <= cfg_wdata[7:0];
        csd_pkg::CFG_FN_OP:     fn_op_r     <= cfg_wdata[7:0];
        csd_pkg::CFG_NAME_LIM:  name_lim_r  <= cfg_wdata[7:0];
        csd_pkg::CFG_MAX_LEN:   max_len_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csd_pkg::PH_IDLE;
      idx_r   <= '0;
      need_r  <= '0;
      op_r    <= '0;
      bcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      need_r  <= need_nxt;
      op_r    <= op_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    held2_r <= held2_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    need_nxt  = need_r;
    op_nxt    = op_r;
    bcnt_nxt  = bcnt_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    held2_nxt = held2_r;
    push      = 1'b0;
    cmd       = '0;
    cmd.cnt   = 3'd1;
    cmd.dat[0] = b;
    if (accept) begin
      if (in_ch.link_reset) begin
        phase_nxt = csd_pkg::PH_IDLE;
        idx_nxt   = '0;
        need_nxt  = '0;
        op_nxt    = '0;
        bcnt_nxt  = '0;
      end else begin
        case (phase_r)
          csd_pkg::PH_IDLE: begin
            if (b == stream_op_r) begin
              held0_nxt = b;
              op_nxt    = b;
              idx_nxt   = 17'd1;
              phase_nxt = csd_pkg::PH_STR_HDR;
            end else if (b <= max_bin_r) begin
              if (b == 8'd0) begin
                push            = 1'b1;
                cmd.kind        = csd_pkg::KIND_BINARY;
                cmd.flen        = 16'd1;
                cmd.first_start = 1'b1;
                cmd.last_end    = 1'b1;
              end else begin
                held0_nxt = b;
                need_nxt  = 32'd1 + {24'd0, b};
                idx_nxt   = 17'd1;
                phase_nxt = csd_pkg::PH_BIN;
              end
            end else if (b == bulk_op_r) begin
              op_nxt          = b;
              need_nxt        = '0;
              idx_nxt         = 17'd1;
              push            = 1'b1;
              cmd.kind        = csd_pkg::KIND_BULK_HDR;
              cmd.op          = b;
              cmd.flen        = csd_pkg::BULK_HDR_BYTES;
              cmd.first_start = 1'b1;
              phase_nxt       = csd_pkg::PH_BULK_HDR;
            end else if (b == fn_op_r) begin
              held0_nxt = b;
              op_nxt    = b;
              idx_nxt   = 17'd1;
              phase_nxt = csd_pkg::PH_FN_HDR;
            end else begin
              push            = 1'b1;
              cmd.kind        = csd_pkg::KIND_DROP;
              cmd.op          = b;
              cmd.reason      = csd_pkg::RSN_UNKNOWN;
              cmd.first_start = 1'b1;
              cmd.last_end    = 1'b1;
            end
          end
          csd_pkg::PH_BIN: begin
            push         = 1'b1;
            cmd.kind     = csd_pkg::KIND_BINARY;
            cmd.flen     = need_r[15:0];
            cmd.last_end = idx_end;
            idx_nxt      = idx_inc;
            if (idx_r == 17'd1) begin
              op_nxt          = b;
              cmd.cnt         = 3'd2;
              cmd.dat[0]      = held0_r;
              cmd.dat[1]      = b;
              cmd.op          = b;
              cmd.first_start = 1'b1;
            end else begin
              cmd.op = op_r;
            end
            if (idx_end) phase_nxt = csd_pkg::PH_IDLE;
          end
          csd_pkg::PH_STR_HDR: begin
            if (idx_r == 17'd1) begin
              held1_nxt = b;
              idx_nxt   = 17'd2;
            end else if (str_big) begin
              push            = 1'b1;
              cmd.kind        = csd_pkg::KIND_DROP;
              cmd.op          = op_r;
              cmd.reason      = csd_pkg::RSN_OVERSIZED;
              cmd.first_start = 1'b1;
              cmd.last_end    = 1'b1;
              phase_nxt       = csd_pkg::PH_IDLE;
            end else begin
              push            = 1'b1;
              need_nxt        = {15'd0, str_total};
              cmd.cnt         = 3'd3;
              cmd.dat[0]      = held0_r;
              cmd.dat[1]      = held1_r;
              cmd.dat[2]      = b;
              cmd.kind        = csd_pkg::KIND_STREAM;
              cmd.op          = op_r;
              cmd.flen        = str_total[15:0];
              cmd.first_start = 1'b1;
              cmd.last_end    = str_total == csd_pkg::STREAM_HDR_BYTES;
              idx_nxt         = 17'd3;
              phase_nxt       = (str_total == csd_pkg::STREAM_HDR_BYTES)
                                ? csd_pkg::PH_IDLE : csd_pkg::PH_STR_BODY;
            end
          end
          csd_pkg::PH_STR_BODY: begin
            push         = 1'b1;
            idx_nxt      = idx_inc;
            cmd.kind     = csd_pkg::KIND_STREAM;
            cmd.op       = op_r;
            cmd.flen     = need_r[15:0];
            cmd.last_end = idx_end;
            if (idx_end) phase_nxt = csd_pkg::PH_IDLE;
          end
          csd_pkg::PH_BULK_HDR: begin
            push         = 1'b1;
            need_nxt     = bulk_need;
            idx_nxt      = idx_inc;
            cmd.kind     = csd_pkg::KIND_BULK_HDR;
            cmd.op       = op_r;
            cmd.flen     = csd_pkg::BULK_HDR_BYTES;
            cmd.last_end = bulk_end;
            cmd.plen     = bulk_end ? bulk_need : 32'd0;
            if (bulk_end) begin
              bcnt_nxt  = '0;
              phase_nxt = (bulk_need == 32'd0) ? csd_pkg::PH_IDLE
                                                : csd_pkg::PH_BULK_PAY;
            end
          end
          csd_pkg::PH_BULK_PAY: begin
            push            = 1'b1;
            bcnt_nxt        = pay_inc;
            cmd.kind        = csd_pkg::KIND_BULK_PAY;
            cmd.op          = op_r;
            cmd.plen        = need_r;
            cmd.first_start = bcnt_r == 32'd0;
            cmd.last_end    = pay_end;
            if (pay_end) phase_nxt = csd_pkg::PH_IDLE;
          end
          csd_pkg::PH_FN_HDR: begin
            if (idx_r < 17'd3) begin
              if (idx_r == 17'd1) begin
                held1_nxt = b;
              end else begin
                held2_nxt = b;
              end
              idx_nxt = idx_inc;
            end else if (fn_bad) begin
              push            = 1'b1;
              cmd.kind        = csd_pkg::KIND_DROP;
              cmd.op          = op_r;
              cmd.reason      = csd_pkg::RSN_BAD_NAME;
              cmd.first_start = 1'b1;
              cmd.last_end    = 1'b1;
              phase_nxt       = csd_pkg::PH_IDLE;
            end else begin
              push            = 1'b1;
              need_nxt        = {23'd0, fn_total};
              cmd.cnt         = 3'd5;
              cmd.dat[0]      = fn_total[7:0];
              cmd.dat[1]      = held0_r;
              cmd.dat[2]      = held1_r;
              cmd.dat[3]      = held2_r;
              cmd.dat[4]      = b;
              cmd.kind        = csd_pkg::KIND_FILENAME;
              cmd.op          = op_r;
              cmd.flen        = {7'd0, fn_total} + 16'd1;
              cmd.first_start = 1'b1;
              idx_nxt         = {8'd0, csd_pkg::FN_HDR_BYTES};
              phase_nxt       = csd_pkg::PH_FN_BODY;
            end
          end
          csd_pkg::PH_FN_BODY: begin
            push         = 1'b1;
            idx_nxt      = idx_inc;
            cmd.kind     = csd_pkg::KIND_FILENAME;
            cmd.op       = op_r;
            cmd.flen     = need_r[15:0] + 16'd1;
            cmd.last_end = idx_end;
            if (idx_end) phase_nxt = csd_pkg::PH_IDLE;
          end
          default: phase_nxt = csd_pkg::PH_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### rtl/csd_queue.sv
// ----------------------------------------------------------------------------
// csd_queue
// short command queue between parser and result sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module csd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  csd_pkg::cmd_t      wr_cmd,
  input  wire logic          pop,
  output csd_pkg::cmd_t      rd_cmd,
  output logic               full,
  output logic               empty
);

  csd_pkg::cmd_t mem_r [csd_pkg::Q_DEPTH];
  logic [csd_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [csd_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = cnt_r == csd_pkg::Q_CNT_W'(csd_pkg::Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_cmd;
  end

endmodule

`default_nettype wire

### rtl/csd_back.sv
// ----------------------------------------------------------------------------
// csd_back
// result sequencer: expands each command into its results, one per cycle
// while the output is ready, through a registered output stage
// ----------------------------------------------------------------------------
`default_nettype none

module csd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  csd_pkg::cmd_t      q_cmd,
  input  wire logic          q_empty,
  output logic               pop,
  csd_out_if.source          out_ch
);

  csd_pkg::cmd_t cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [csd_pkg::RES_IDX_W-1:0] sel_r, sel_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [2:0]  kind_r;
  logic [7:0]  data_r;
  logic        start_r, end_r, run_end_r;
  logic [7:0]  op_r;
  logic [15:0] flen_r;
  logic [31:0] plen_r;
  logic [1:0]  reason_r;

  logic can_load, out_load, is_last, cur_free;

  assign can_load = !out_valid_r || out_ch.ready;
  assign out_load = cur_valid_r && can_load;
  assign is_last  = sel_r == (cur_r.cnt - 3'd1);
  assign cur_free = !cur_valid_r || (out_load && is_last);
  assign pop      = cur_free && !q_empty;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    sel_nxt       = sel_r;
    if (pop) begin
      cur_nxt       = q_cmd;
      cur_valid_nxt = 1'b1;
      sel_nxt       = '0;
    end else if (out_load && is_last) begin
      cur_valid_nxt = 1'b0;
    end else if (out_load) begin
      sel_nxt = sel_r + 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (out_load) begin
      kind_r    <= cur_r.kind;
      data_r    <= cur_r.dat[sel_r];
      start_r   <= cur_r.first_start && (sel_r == '0);
      end_r     <= cur_r.last_end && is_last;
      run_end_r <= is_last;
      op_r      <= cur_r.op;
      flen_r    <= cur_r.flen;
      plen_r    <= cur_r.plen;
      reason_r  <= cur_r.reason;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.data        = data_r;
  assign out_ch.frame_start = start_r;
  assign out_ch.frame_end   = end_r;
  assign out_ch.frame_op    = op_r;
  assign out_ch.frame_len   = flen_r;
  assign out_ch.bulk_len    = plen_r;
  assign out_ch.drop_reason = reason_r;
  assign out_ch.run_end     = run_end_r;

endmodule

`default_nettype wire

### rtl/command_stream_deframer_top.sv
// ----------------------------------------------------------------------------
// command_stream_deframer_top
// splits a received byte stream into binary, stream, bulk and filename
// command frames, reporting drops with a reason
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the 4-entry command queue has
// room; the parser turns each byte into at most one command, and the result
// sequencer plays each command out as 1 to 5 results at one result per cycle
// while the output is ready. Body and payload bytes thus flow at one byte
// per cycle; a header byte releases its held results one after another, and
// the queue absorbs these bursts. A byte's first result passes through the
// queue entry, current command and output registers. A link_reset item
// clears the parser, yields no result and keeps the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module command_stream_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  csd_in_if.sink           in_ch,
  csd_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  csd_pkg::cmd_t wr_cmd, rd_cmd;
  logic push, pop, q_full, q_empty;

  csd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  csd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  csd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (rd_cmd),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
